@@ design/srdg_pkg.sv @@
// srdg_pkg: shared types and constants of the stepper ramp delay generator
// no dependencies; imported by every module of the block but srdg_divider

package srdg_pkg;

  // divider dividend width: 2*count (33 bits) and the scaled delay numerator (26 bits at the default fraction width)
  localparam int DIV_W = 34;

  // count, result and configuration widths
  localparam int COUNT_W = 32;
  localparam int DELAY_W = 24;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_CFG_W = 20;

  // constant divisors: 2*c0/5 at restart, the residual /3 of the delay scale 10/12
  localparam int RESTART_DIV = 5;
  localparam int DELAY_DIV = 3;
  localparam int DELAY_MUL = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_END_STEP   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_START_STEP = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_STEPS      = 4'd3;

  // count update selected when a word is decoded
  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACCEL,
    OP_DECEL
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_DLY_START,
    ST_DLY_WAIT,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic decode;
    logic update;
    logic dly_start;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic skip_div;
  } stat_t;

endpackage

@@ design/srdg_divider.sv @@
// srdg_divider: unsigned restoring divider, two quotient bits per cycle
// no package dependencies; instantiated by srdg_datapath

module srdg_divider #(
  parameter int DW = 34,
  parameter int VW = 22
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int HALF  = (DW + 1) / 2;
  localparam int QW    = 2 * HALF;
  localparam int CNT_W = $clog2(HALF + 1);

  logic [QW-1:0]    quo_r, quo_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic [VW-1:0]    den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [VW:0]      s1, s2;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [VW:0] div_bit(input logic [VW-1:0] rem, input logic b,
                                          input logic [VW-1:0] den);
    logic [VW:0] t;
    t = {rem, b};
    if (t >= {1'b0, den}) begin
      div_bit = {1'b1, VW'(t - {1'b0, den})};
    end else begin
      div_bit = {1'b0, t[VW-1:0]};
    end
  endfunction

  // two dependent steps per cycle
  assign s1 = div_bit(rem_r, quo_r[QW-1], den_r);
  assign s2 = div_bit(s1[VW-1:0], quo_r[QW-2], den_r);

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = QW'(dividend);
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CNT_W'(HALF);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[QW-3:0], s1[VW], s2[VW]};
      rem_nxt = s2[VW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r[DW-1:0];

endmodule

@@ design/srdg_datapath.sv @@
// srdg_datapath: configuration, step and count state, divider operand select, output word
// depends on srdg_pkg and srdg_divider

module srdg_datapath
  import srdg_pkg::*;
#(
  parameter int STEP_BITS       = 20,
  parameter int COUNT_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  in_restart,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [DELAY_W-1:0]    out_delay,
  output logic                  out_done
);

  localparam int VW     = STEP_BITS + 2;
  localparam int CW     = (STEP_BITS < STEP_CFG_W) ? STEP_BITS : STEP_CFG_W;
  localparam int SHIFT  = COUNT_FRAC_BITS + 2;
  localparam int NUM_W  = COUNT_W + 4;
  localparam logic [NUM_W-1:0] ROUND_UP = NUM_W'((64'(DELAY_DIV) << SHIFT) - 64'd1);

  logic [COUNT_W-1:0]   c0_r;
  logic [STEP_BITS-1:0] accel_r, decel_r, total_r;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 finished_r, finished_nxt;
  op_t                  op_r, op_nxt;
  logic                 restart_r;
  logic [DELAY_W-1:0]   out_delay_r;
  logic                 out_done_r;

  logic [STEP_BITS-1:0] cfg_step;
  logic [STEP_BITS-1:0] step_inc, total_m1, remain;
  logic [VW-1:0]        step_divisor;
  logic                 div_start, div_busy, div_done;
  logic [DIV_W-1:0]     div_dividend, div_quot;
  logic [VW-1:0]        div_divisor;
  logic [NUM_W-1:0]     dly_num, dly_shifted;
  logic [COUNT_W:0]     decel_sum;

  // configuration registers, step fields masked to the step width
  assign cfg_step = STEP_BITS'(cfg_wdata[CW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r    <= '0;
      accel_r <= '0;
      decel_r <= '0;
      total_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_INITIAL_COUNT:    c0_r    <= cfg_wdata[COUNT_W-1:0];
        CFG_ACCEL_END_STEP:   accel_r <= cfg_step;
        CFG_DECEL_START_STEP: decel_r <= cfg_step;
        CFG_TOTAL_STEPS:      total_r <= cfg_step;
        default: ;
      endcase
    end
  end

  // step arithmetic
  assign step_inc = step_r + 1'b1;
  assign total_m1 = total_r - 1'b1;
  assign remain   = total_r - step_inc;

  // decode: next step, done flag, count update kind and its divisor
  always_comb begin
    step_nxt     = step_r;
    finished_nxt = finished_r;
    op_nxt       = op_r;
    step_divisor = VW'(RESTART_DIV);
    if (cmd.decode) begin
      op_nxt = OP_NONE;
      if (restart_r) begin
        op_nxt       = OP_LOAD;
        step_nxt     = STEP_BITS'(1);
        finished_nxt = (STEP_BITS'(1) == total_m1);
      end else if (!finished_r) begin
        step_nxt     = step_inc;
        finished_nxt = (step_inc == total_m1);
        if (step_inc <= accel_r) begin
          op_nxt       = OP_ACCEL;
          step_divisor = {step_inc, 2'b01};
        end else if ((step_inc > decel_r) && (remain != '0)) begin
          op_nxt       = OP_DECEL;
          step_divisor = {remain, 2'b00} - 1'b1;
        end
      end
    end
  end

  // delay numerator: count*10 plus 3*2^(frac+2)-1, scaled down by 2^(frac+2),
  // so the floored /3 in the divider gives the ceiling of count*10/(12*2^frac)
  assign dly_num     = NUM_W'(count_r) * NUM_W'(DELAY_MUL) + ROUND_UP;
  assign dly_shifted = dly_num >> SHIFT;

  // divider operand select
  assign div_start = (cmd.decode && (op_nxt != OP_NONE)) || cmd.dly_start;

  always_comb begin
    if (cmd.dly_start) begin
      div_dividend = dly_shifted[DIV_W-1:0];
      div_divisor  = VW'(DELAY_DIV);
    end else if (restart_r) begin
      div_dividend = DIV_W'({c0_r, 1'b0});
      div_divisor  = step_divisor;
    end else begin
      div_dividend = DIV_W'({count_r, 1'b0});
      div_divisor  = step_divisor;
    end
  end

  srdg_divider #(
    .DW (DIV_W),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // count update from the quotient
  assign decel_sum = {1'b0, count_r} + div_quot[COUNT_W:0];

  always_comb begin
    count_nxt = count_r;
    if (cmd.update) begin
      case (op_r)
        OP_LOAD:  count_nxt = c0_r - div_quot[COUNT_W-1:0];
        OP_ACCEL: begin
          if (div_quot > DIV_W'(count_r)) begin
            count_nxt = '0;
          end else begin
            count_nxt = count_r - div_quot[COUNT_W-1:0];
          end
        end
        OP_DECEL: begin
          if (decel_sum[COUNT_W]) begin
            count_nxt = COUNT_MAX;
          end else begin
            count_nxt = decel_sum[COUNT_W-1:0];
          end
        end
        default: count_nxt = count_r;
      endcase
    end
  end

  // motion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      count_r    <= '0;
      finished_r <= 1'b1;
      op_r       <= OP_NONE;
    end else begin
      step_r     <= step_nxt;
      count_r    <= count_nxt;
      finished_r <= finished_nxt;
      op_r       <= op_nxt;
    end
  end

  // captured input word and output word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      restart_r <= in_restart;
    end
    if (cmd.out_load) begin
      out_delay_r <= (div_quot > DIV_W'(DELAY_MAX)) ? DELAY_MAX : div_quot[DELAY_W-1:0];
      out_done_r  <= finished_r;
    end
  end

  assign out_delay = out_delay_r;
  assign out_done  = out_done_r;

  assign stat.div_done = div_done;
  assign stat.div_busy = div_busy;
  assign stat.skip_div = (op_r == OP_NONE);

endmodule

@@ design/srdg_ctrl.sv @@
// srdg_ctrl: word sequencer: decode, count division if any, delay division, output
// depends on srdg_pkg

module srdg_ctrl
  import srdg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // state register and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.skip_div) begin
          state_nxt = ST_DLY_START;
        end else if (stat.div_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DLY_START;
      end
      ST_DLY_START: begin
        cmd.dly_start = 1'b1;
        state_nxt     = ST_DLY_WAIT;
      end
      ST_DLY_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/stepper_ramp_delay_generator_unit.sv @@
// Stepper ramp delay generator: per-step timer delays for a trapezoidal stepper speed
// profile. Each input word (restart or advance) yields one output word with the delay to
// the next pulse and a done flag. The shared radix-4 divider sets the time of a word: it
// runs once for the count update, which is skipped when the count does not change (cruise,
// finished or the step equal to the total), and once for the delay scaling. The input
// opens again once the result is loaded into the output register, so the next word is
// taken while that result waits. Configuration writes are taken every cycle and belong
// between moves. Depends on srdg_pkg, srdg_ctrl, srdg_datapath and srdg_divider.

module stepper_ramp_delay_generator_unit
  import srdg_pkg::*;
#(
  parameter int STEP_BITS       = 20,
  parameter int COUNT_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] restart, [7:1] zero
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DELAY_W-1:0]    out_tdata,  // [23:0] pulse_delay
  output logic                  out_tlast,  // move_done
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // configuration always taken
  assign cfg_ready = 1'b1;

  // sequencer
  srdg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // state, arithmetic and output word
  srdg_datapath #(
    .STEP_BITS       (STEP_BITS),
    .COUNT_FRAC_BITS (COUNT_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_restart (in_tdata[0]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .out_delay  (out_tdata),
    .out_done   (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // an accepted word closes the input until its result is produced
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a word is in progress");

  // the delay division never restarts the divider mid-division
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dly_start |-> !stat.div_busy)
    else $error("delay division started while divider busy");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output word overwritten before it was taken");

  // a division finishes only while a word is in progress
  a_done_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> !in_tready)
    else $error("divider finished while idle");
`endif

endmodule

@@ dv/stepper_ramp_delay_generator_unit_tb.sv @@
// testbench for stepper_ramp_delay_generator_unit: random and directed restart/advance words
// checked against a cycle-free model of the ramp recurrence; depends on srdg_pkg and the rtl

module stepper_ramp_delay_generator_unit_tb;
  import srdg_pkg::*;

  localparam int STEP_W = 20;
  localparam int FRAC_BITS = 8;
  localparam longint unsigned DELAY_DIVISOR = 64'd12 << FRAC_BITS;
  localparam int RANDOM_WORDS = 1900;

  // one expected result word
  typedef struct packed {
    logic [DELAY_W-1:0] pulse_delay;
    logic               move_done;
  } delay_word_t;

  // ramp model plus the queue of delays still owed by the block
  class ramp_scoreboard;
    logic [31:0]       c0;
    logic [STEP_W-1:0] accel_end;
    logic [STEP_W-1:0] decel_start;
    logic [STEP_W-1:0] total;
    logic [STEP_W-1:0] step;
    logic [31:0]       count;
    logic              finished;
    delay_word_t       owed_delays[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      c0 = '0;
      accel_end = '0;
      decel_start = '0;
      total = '0;
      step = '0;
      count = '0;
      finished = 1'b1;
      errors = 0;
      checked = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_INITIAL_COUNT:    c0 = data;
        CFG_ACCEL_END_STEP:   accel_end = data[STEP_W-1:0];
        CFG_DECEL_START_STEP: decel_start = data[STEP_W-1:0];
        CFG_TOTAL_STEPS:      total = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the ramp by one accepted word and queue the delay it yields
    function void note_step_word(logic restart);
      longint unsigned c;
      longint unsigned dec;
      longint unsigned num;
      longint unsigned dly;
      logic [STEP_W-1:0] last_step;
      logic [STEP_W-1:0] steps_left;
      delay_word_t w;
      c = 64'(count);
      last_step = total - 1'b1;
      if (restart) begin
        step = STEP_W'(1);
        c = 64'(c0);
        c = c - (2 * c) / 5;
        count = c[31:0];
        finished = (step == last_step);
      end else if (!finished) begin
        step = step + 1'b1;
        if (step <= accel_end) begin
          // acceleration: count shrinks, floored at zero
          dec = (2 * c) / (4 * step + 1);
          c = (dec > c) ? 0 : c - dec;
        end else if (step > decel_start) begin
          // deceleration: count grows, saturates at the 32-bit max
          steps_left = total - step;
          if (steps_left != 0) begin
            c = c + (2 * c) / (4 * steps_left - 1);
            if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
          end
        end
        count = c[31:0];
        finished = (step == last_step);
      end
      num = 64'(count);
      num = num * 10;
      dly = (num + DELAY_DIVISOR - 1) / DELAY_DIVISOR;
      if (dly > 64'hFF_FFFF) dly = 64'hFF_FFFF;
      w.pulse_delay = dly[DELAY_W-1:0];
      w.move_done = finished;
      owed_delays.push_back(w);
    endfunction

    function void check_delay_word(logic [DELAY_W-1:0] pulse_delay, logic move_done);
      delay_word_t w;
      if (owed_delays.size() == 0) begin
        $error("result word with nothing expected: pulse_delay=%0d move_done=%0b",
               pulse_delay, move_done);
        errors++;
        return;
      end
      w = owed_delays.pop_front();
      checked++;
      if (pulse_delay !== w.pulse_delay) begin
        $error("pulse_delay mismatch: expected %0d, actual %0d", w.pulse_delay, pulse_delay);
        errors++;
      end
      if (move_done !== w.move_done) begin
        $error("move_done mismatch: expected %0b, actual %0b", w.move_done, move_done);
        errors++;
      end
    endfunction

    function int pending();
      return owed_delays.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [0] restart, [7:1] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DELAY_W-1:0]    out_tdata;       // [23:0] pulse_delay
  logic                  out_tlast;       // move_done
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ramp_scoreboard sb;
  int unsigned    words_sent = 0;
  int unsigned    burst_left = 0;
  int unsigned    profiles = 0;

  stepper_ramp_delay_generator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watch all three handshakes; results are checked before the new word is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_delay_word(out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_step_word(in_tdata[0]);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
    end
  end

  // receiver back-pressure: phases of always ready, random stalls, or a fixed duty pattern
  int unsigned rx_phase_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_tick = 0;
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_phase_left <= $urandom_range(50, 400);
      rx_tick <= 0;
    end else begin
      rx_phase_left <= rx_phase_left - 1;
      rx_tick <= rx_tick + 1;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 2) != 0);
      default: out_tready <= ((rx_tick % 7) >= 3);
    endcase
  end

  // drive one word, opening a new burst, mostly after a random gap, when the old one runs out
  task automatic send_word(input logic restart);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // stop sending and wait until every owed result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_profile(input logic [31:0] c0, input logic [STEP_W-1:0] accel,
                                 input logic [STEP_W-1:0] decel,
                                 input logic [STEP_W-1:0] total);
    wait_idle();
    cfg_write(CFG_INITIAL_COUNT, c0);
    cfg_write(CFG_ACCEL_END_STEP, {{(CFG_DATA_W-STEP_W){1'b0}}, accel});
    cfg_write(CFG_DECEL_START_STEP, {{(CFG_DATA_W-STEP_W){1'b0}}, decel});
    cfg_write(CFG_TOTAL_STEPS, {{(CFG_DATA_W-STEP_W){1'b0}}, total});
    cfg_valid <= 1'b0;
    profiles++;
  endtask

  // odd step settings: tiny, full-range or all ones
  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 3))
      0: return STEP_W'($urandom_range(0, 4));
      1: return '1;
      default: return STEP_W'($urandom_range(0, (1 << STEP_W) - 1));
    endcase
  endfunction

  initial begin
    int unsigned       kind;
    int unsigned       target;
    int unsigned       n;
    logic [31:0]       c0;
    logic [STEP_W-1:0] accel;
    logic [STEP_W-1:0] decel;
    logic [STEP_W-1:0] total;

    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // advances while idle after reset, then a restart with every register at zero
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);

    // largest first count, saturating in deceleration
    program_profile(32'hFFFF_FFFF, '0, '0, 4);
    send_word(1'b1);
    repeat (3) send_word(1'b0);

    // done right at restart, advance ignored after it
    program_profile(32'h0012_3456, '0, '0, 2);
    send_word(1'b1);
    send_word(1'b0);

    // total of one: the step runs past the total in deceleration
    program_profile(32'h1234_5678, '0, '0, 1);
    send_word(1'b1);
    repeat (2) send_word(1'b0);

    // ordinary trapezoid through all three segments, one advance past done
    program_profile(32'h0100_0000, 3, 5, 9);
    send_word(1'b1);
    repeat (8) send_word(1'b0);

    // zero count with every step register at its top
    program_profile('0, '1, '1, '1);
    send_word(1'b1);
    send_word(1'b0);

    // random moves: mostly well-formed ramps, mixed with odd settings, aborted moves and noise
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 8) begin
        if (kind == 7) begin
          total = pick_step();
          accel = pick_step();
          decel = pick_step();
        end else begin
          total = STEP_W'($urandom_range(3, 40));
          accel = STEP_W'($urandom_range(0, total / 2));
          decel = STEP_W'($urandom_range(accel, total));
        end
        case ($urandom_range(0, 9))
          0: c0 = '1;
          1: c0 = '0;
          default: c0 = $urandom >> $urandom_range(0, 24);
        endcase
        program_profile(c0, accel, decel, total);
      end
      case (kind)
        7: begin
          send_word(1'b1);
          repeat ($urandom_range(0, 20)) send_word(1'b0);
        end
        8: begin
          n = total + 2;
          send_word(1'b1);
          repeat (n) send_word($urandom_range(0, 7) == 0);
        end
        9: begin
          repeat ($urandom_range(1, 10)) send_word($urandom_range(0, 3) == 0);
        end
        default: begin
          n = total - 2 + $urandom_range(0, 2);
          send_word(1'b1);
          repeat (n) send_word(1'b0);
        end
      endcase
    end

    // drain, then give the block time to show any stray result word
    wait_idle();
    repeat (60) @(posedge clk);

    $display("covered %0d words over %0d register settings; %0d result words checked",
             words_sent, profiles, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #6_000_000;
    $error("timeout with %0d result words still owed", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ stepper_ramp_delay_generator_unit.f @@
design/srdg_pkg.sv
design/srdg_divider.sv
design/srdg_datapath.sv
design/srdg_ctrl.sv
design/stepper_ramp_delay_generator_unit.sv
dv/stepper_ramp_delay_generator_unit_tb.sv
